FILE: sv/hbmd_pkg.sv
package hbmd_pkg;

    // default motor count and the widest motor count the id field can address
    localparam int NUM_MOTORS_DEF = 4;
    localparam int MOTOR_ID_W     = 3;
    localparam int DUTY_W         = 15;
    localparam int REQ_W          = 16;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // configuration
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 15'd1000;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DUTY_LIMIT = 1'b0;

    // request modes
    localparam logic [2:0] MODE_SET       = 3'd0;
    localparam logic [2:0] MODE_BRAKE     = 3'd1;
    localparam logic [2:0] MODE_COAST     = 3'd2;
    localparam logic [2:0] MODE_BRAKE_ALL = 3'd3;
    localparam logic [2:0] MODE_COAST_ALL = 3'd4;
    localparam logic [2:0] MODE_ESTOP     = 3'd5;
    localparam logic [2:0] MODE_QUERY     = 3'd6;

    // drive directions
    localparam logic [1:0] DIR_COAST = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_REV   = 2'd2;
    localparam logic [1:0] DIR_BRAKE = 2'd3;

    typedef struct packed {
        logic [2:0]              mode;
        logic [MOTOR_ID_W-1:0]   motor_id;
        logic signed [REQ_W-1:0] signed_duty;
    } t_in_req;

    typedef struct packed {
        logic [MOTOR_ID_W-1:0] motor_num;
        logic                  right_enable;
        logic                  left_enable;
        logic [DUTY_W-1:0]     duty_out;
        logic [1:0]            drive_dir;
        logic                  running;
        logic                  guard_hit;
        logic                  last;
    } t_out_res;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_SET       = 3'd0,
        OP_BRAKE     = 3'd1,
        OP_COAST     = 3'd2,
        OP_BRAKE_ALL = 3'd3,
        OP_COAST_ALL = 3'd4,
        OP_QUERY     = 3'd5
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [MOTOR_ID_W-1:0] motor;
        logic                  neg;
        logic [DUTY_W-1:0]     mag;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'b01,
        BS_SWEEP = 2'b10
    } t_bstate;

endpackage

FILE: sv/hbmd_front.sv
module hbmd_front #(
    parameter int NUM_MOTORS = hbmd_pkg::NUM_MOTORS_DEF
) (
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hbmd_pkg::t_in_req               i_in_req,
    input  logic [hbmd_pkg::DUTY_W-1:0]     i_duty_limit,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output hbmd_pkg::t_cmd                  o_q_cmd
);

    logic                      w_in_range;
    logic                      w_keep;
    logic [hbmd_pkg::REQ_W:0]  w_mag_raw;
    logic [hbmd_pkg::DUTY_W-1:0] w_mag;

    // motor id range check
    assign w_in_range = ({1'b0, i_in_req.motor_id} <
                         (hbmd_pkg::MOTOR_ID_W + 1)'(NUM_MOTORS));

    // magnitude of the requested duty, clamped to the limit
    always_comb begin
        if (i_in_req.signed_duty[hbmd_pkg::REQ_W-1]) begin
            w_mag_raw = (hbmd_pkg::REQ_W + 1)'(0) -
                        {i_in_req.signed_duty[hbmd_pkg::REQ_W-1], i_in_req.signed_duty};
        end else begin
            w_mag_raw = {1'b0, i_in_req.signed_duty};
        end
        if (w_mag_raw > {2'b00, i_duty_limit}) begin
            w_mag = i_duty_limit;
        end else begin
            w_mag = w_mag_raw[hbmd_pkg::DUTY_W-1:0];
        end
    end

    // classify the request; the unused mode and out-of-range motors of single-motor modes are dropped
    always_comb begin
        o_q_cmd.motor = i_in_req.motor_id;
        o_q_cmd.neg   = i_in_req.signed_duty[hbmd_pkg::REQ_W-1];
        o_q_cmd.mag   = w_mag;
        o_q_cmd.op    = hbmd_pkg::OP_QUERY;
        w_keep        = 1'b0;
        case (i_in_req.mode)
            hbmd_pkg::MODE_SET: begin
                o_q_cmd.op = hbmd_pkg::OP_SET;
                w_keep     = w_in_range;
            end
            hbmd_pkg::MODE_BRAKE: begin
                o_q_cmd.op = hbmd_pkg::OP_BRAKE;
                w_keep     = w_in_range;
            end
            hbmd_pkg::MODE_COAST: begin
                o_q_cmd.op = hbmd_pkg::OP_COAST;
                w_keep     = w_in_range;
            end
            hbmd_pkg::MODE_BRAKE_ALL: begin
                o_q_cmd.op = hbmd_pkg::OP_BRAKE_ALL;
                w_keep     = 1'b1;
            end
            hbmd_pkg::MODE_COAST_ALL,
            hbmd_pkg::MODE_ESTOP: begin
                o_q_cmd.op = hbmd_pkg::OP_COAST_ALL;
                w_keep     = 1'b1;
            end
            hbmd_pkg::MODE_QUERY: begin
                o_q_cmd.op = hbmd_pkg::OP_QUERY;
                w_keep     = w_in_range;
            end
            default: begin
                o_q_cmd.op = hbmd_pkg::OP_QUERY;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full && w_keep;

endmodule

FILE: sv/hbmd_queue.sv
module hbmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hbmd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hbmd_pkg::t_cmd o_cmd
);

    hbmd_pkg::t_cmd               r_mem [hbmd_pkg::QDEPTH];
    logic [hbmd_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [hbmd_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [hbmd_pkg::QPTR_W:0]    r_count;
    logic [hbmd_pkg::QPTR_W:0]    n_count;
    logic                         w_push;
    logic                         w_pop;

    assign o_full  = (r_count == (hbmd_pkg::QPTR_W + 1)'(hbmd_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

FILE: sv/hbmd_back.sv
module hbmd_back #(
    parameter int NUM_MOTORS = hbmd_pkg::NUM_MOTORS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  hbmd_pkg::t_cmd     i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hbmd_pkg::t_out_res o_out_res
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MOTORS - 1);

    // per-motor drive state
    logic [1:0]                  r_dir  [NUM_MOTORS];
    logic [hbmd_pkg::DUTY_W-1:0] r_duty [NUM_MOTORS];
    logic                        r_run  [NUM_MOTORS];

    hbmd_pkg::t_bstate           r_state;
    hbmd_pkg::t_bstate           n_state;
    logic [IDX_W-1:0]            r_cnt;
    logic                        r_sweep_brake;
    logic                        r_out_valid;
    hbmd_pkg::t_out_res          r_out;

    logic                        w_can_load;
    logic                        w_load;
    logic                        w_wr;
    logic [IDX_W-1:0]            w_idx;
    logic [1:0]                  w_dir;
    logic [hbmd_pkg::DUTY_W-1:0] w_duty;
    logic                        w_run;
    logic                        w_guard;
    logic                        w_last;
    logic [1:0]                  w_cur;
    logic [1:0]                  w_nd;

    assign w_can_load = !r_out_valid || i_out_ready;
    assign o_q_pop    = (r_state == hbmd_pkg::BS_IDLE) && !i_q_empty && w_can_load;
    assign w_cur      = r_dir[i_q_cmd.motor[IDX_W-1:0]];
    assign w_nd       = i_q_cmd.neg ? hbmd_pkg::DIR_REV : hbmd_pkg::DIR_FWD;

    // execute one command step: new state of one motor and its result
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_wr    = 1'b0;
        w_idx   = i_q_cmd.motor[IDX_W-1:0];
        w_dir   = r_dir[i_q_cmd.motor[IDX_W-1:0]];
        w_duty  = r_duty[i_q_cmd.motor[IDX_W-1:0]];
        w_run   = r_run[i_q_cmd.motor[IDX_W-1:0]];
        w_guard = 1'b0;
        w_last  = 1'b1;
        case (r_state)
            hbmd_pkg::BS_IDLE: begin
                if (o_q_pop) begin
                    case (i_q_cmd.op)
                        hbmd_pkg::OP_SET: begin
                            w_load = 1'b1;
                            w_wr   = 1'b1;
                            if (i_q_cmd.mag == '0) begin
                                w_dir  = hbmd_pkg::DIR_COAST;
                                w_duty = '0;
                                w_run  = 1'b0;
                            end else if (w_cur != w_nd &&
                                         (w_cur == hbmd_pkg::DIR_FWD ||
                                          w_cur == hbmd_pkg::DIR_REV)) begin
                                // reversal guard: coast this time
                                w_dir   = hbmd_pkg::DIR_COAST;
                                w_duty  = '0;
                                w_run   = 1'b0;
                                w_guard = 1'b1;
                            end else begin
                                w_dir  = w_nd;
                                w_duty = i_q_cmd.mag;
                                w_run  = 1'b1;
                            end
                        end
                        hbmd_pkg::OP_BRAKE: begin
                            w_load = 1'b1;
                            w_wr   = 1'b1;
                            w_dir  = hbmd_pkg::DIR_BRAKE;
                            w_duty = '0;
                            w_run  = 1'b0;
                        end
                        hbmd_pkg::OP_COAST: begin
                            w_load = 1'b1;
                            w_wr   = 1'b1;
                            w_dir  = hbmd_pkg::DIR_COAST;
                            w_duty = '0;
                            w_run  = 1'b0;
                        end
                        hbmd_pkg::OP_QUERY: begin
                            w_load = 1'b1;
                        end
                        hbmd_pkg::OP_BRAKE_ALL,
                        hbmd_pkg::OP_COAST_ALL: begin
                            n_state = hbmd_pkg::BS_SWEEP;
                        end
                        default: begin
                            w_load = 1'b0;
                        end
                    endcase
                end
            end
            hbmd_pkg::BS_SWEEP: begin
                w_idx  = r_cnt;
                w_dir  = r_sweep_brake ? hbmd_pkg::DIR_BRAKE : hbmd_pkg::DIR_COAST;
                w_duty = '0;
                w_run  = 1'b0;
                w_last = (r_cnt == LAST_IDX);
                if (w_can_load) begin
                    w_load = 1'b1;
                    w_wr   = 1'b1;
                    if (r_cnt == LAST_IDX) begin
                        n_state = hbmd_pkg::BS_IDLE;
                    end
                end
            end
            default: begin
                n_state = hbmd_pkg::BS_IDLE;
            end
        endcase
    end

    // motor state storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_dir[k]  <= hbmd_pkg::DIR_COAST;
                r_duty[k] <= '0;
                r_run[k]  <= 1'b0;
            end
        end else if (w_wr) begin
            r_dir[w_idx]  <= w_dir;
            r_duty[w_idx] <= w_duty;
            r_run[w_idx]  <= w_run;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hbmd_pkg::BS_IDLE;
            r_cnt         <= '0;
            r_sweep_brake <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == hbmd_pkg::BS_IDLE) begin
                r_cnt         <= '0;
                r_sweep_brake <= (i_q_cmd.op == hbmd_pkg::OP_BRAKE_ALL);
            end else if (w_can_load) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.motor_num    <= hbmd_pkg::MOTOR_ID_W'(w_idx);
            r_out.right_enable <= (w_dir == hbmd_pkg::DIR_FWD) ||
                                  (w_dir == hbmd_pkg::DIR_BRAKE);
            r_out.left_enable  <= (w_dir == hbmd_pkg::DIR_REV) ||
                                  (w_dir == hbmd_pkg::DIR_BRAKE);
            r_out.duty_out     <= w_duty;
            r_out.drive_dir    <= w_dir;
            r_out.running      <= w_run;
            r_out.guard_hit    <= w_guard;
            r_out.last         <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

FILE: sv/hbridge_motor_direction_control.sv
// H-bridge motor driver for up to eight motors with a reversal dead-time guard.
// Input channel (i_in_valid / o_in_ready / i_in_req) takes one command request:
// set, brake, coast, brake all, coast all, emergency stop or query. The output
// channel (o_out_valid / i_out_ready / o_out_res) returns one result per motor
// touched; the final result of a command has last set. Single-motor requests for
// a motor at or above NUM_MOTORS, and the unused mode, give no result.
// A single-motor request is classified into the queue at the accepting edge and
// executed into the output register when the back end is idle and the output
// register is free. An all-motor command first moves the back end into its sweep
// state, then gives one result a cycle while the receiver takes results; no new
// command is taken from the queue until the sweep has finished.
// Throughput is one single-motor request a cycle while the receiver takes results
// and no sweep runs, set by the back end's one result per cycle.
// A two-entry queue separates request classification from execution, so the
// input stays ready while a result waits; when the receiver stalls, the
// output register holds and the queue fills, then o_in_ready drops.
// Reset (synchronous, active low) coasts every motor with zero duty, empties the
// queue and loads duty_limit with 1000. duty_limit sits at byte address 0 of the
// APB port; the user must write it only while the block is idle (not enforced).
module hbridge_motor_direction_control #(
    parameter int NUM_MOTORS = hbmd_pkg::NUM_MOTORS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hbmd_pkg::t_in_req              i_in_req,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hbmd_pkg::t_out_res             o_out_res,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbmd_pkg::PADDR_W-1:0]   paddr,
    input  logic [hbmd_pkg::PDATA_W-1:0]   pwdata,
    output logic [hbmd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [hbmd_pkg::DUTY_W-1:0] r_duty_limit;
    logic                        w_q_full;
    logic                        w_q_empty;
    logic                        w_q_push;
    logic                        w_q_pop;
    hbmd_pkg::t_cmd              w_push_cmd;
    hbmd_pkg::t_cmd              w_pop_cmd;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_limit <= hbmd_pkg::DUTY_LIMIT_RST;
        end else if (psel && penable && pwrite &&
                     paddr[2] == hbmd_pkg::REG_DUTY_LIMIT) begin
            r_duty_limit <= pwdata[hbmd_pkg::DUTY_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == hbmd_pkg::REG_DUTY_LIMIT) begin
            prdata = {(hbmd_pkg::PDATA_W - hbmd_pkg::DUTY_W)'(0), r_duty_limit};
        end else begin
            prdata = '0;
        end
    end

    // request classification
    hbmd_front #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_duty_limit (r_duty_limit),
        .i_q_full     (w_q_full),
        .o_q_push     (w_q_push),
        .o_q_cmd      (w_push_cmd)
    );

    // command queue
    hbmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_pop_cmd)
    );

    // execution and results
    hbmd_back #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_pop_cmd),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule
